// ----- sv/lbc_pkg.sv -----
// Shared types and constants for the lookahead bass compressor.
package lbc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int ACC_W    = 32;
   localparam int QUOT_W   = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKEUP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 3'd4;

   localparam logic [22:0] THRESHOLD_RST = 23'd4194304;
   localparam logic [15:0] MAKEUP_RST    = 16'd4096;
   localparam logic [15:0] ATTACK_RST    = 16'd65208;
   localparam logic [15:0] RELEASE_RST   = 16'd65503;

   localparam logic [17:0] LP_WEIGHT     = 18'd983;
   localparam logic [17:0] OVER_WEIGHT   = 18'd39322;
   localparam logic [22:0] MIN_THRESHOLD = 23'd8389;
   localparam logic [QUOT_W-1:0] UNITY_GAIN = 17'd65536;
   localparam logic [4:0] DIV_LAST_STEP  = 5'd16;

   typedef struct packed {
      logic        enable;
      logic [22:0] threshold;
      logic [15:0] makeup_gain;
      logic [15:0] attack_coef;
      logic [15:0] release_coef;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [30:0] thr;
      logic [32:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- sv/lbc_csr.sv -----
// Configuration register file for the compressor.
module lbc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]     csr_data,
   output lbc_pkg::cfg_type                   cfg
);
   import lbc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.threshold    <= THRESHOLD_RST;
         cfg_ff.makeup_gain  <= MAKEUP_RST;
         cfg_ff.attack_coef  <= ATTACK_RST;
         cfg_ff.release_coef <= RELEASE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:    cfg_ff.enable       <= csr_data[0];
            CSR_THRESHOLD: cfg_ff.threshold    <= csr_data;
            CSR_MAKEUP:    cfg_ff.makeup_gain  <= csr_data[15:0];
            CSR_ATTACK:    cfg_ff.attack_coef  <= csr_data[15:0];
            CSR_RELEASE:   cfg_ff.release_coef <= csr_data[15:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- sv/lbc_delay_mem.sv -----
// Lookahead delay memory, both channels side by side, registered read.
module lbc_delay_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/lbc_divider.sv -----
// Restoring divider for the gain: (thr << 16) / denom, one quotient bit per cycle.
module lbc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lbc_pkg::div_req_type div_req,
   output lbc_pkg::div_rsp_type div_rsp
);
   import lbc_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [4:0]        cnt_ff;
   logic [32:0]       rem_ff;
   logic [32:0]       denom_ff;
   logic              lsb_ff;
   logic [QUOT_W-1:0] quot_ff;

   logic [33:0] shifted;
   logic        fits;
   logic [33:0] diff;
   logic [32:0] rem_in;

   // only the first step brings in a dividend bit (thr[0]); the rest shift in zeros
   always_comb begin
      shifted = {rem_ff, (cnt_ff == DIV_LAST_STEP) ? lsb_ff : 1'b0};
      fits    = shifted >= {1'b0, denom_ff};
      diff    = shifted - {1'b0, denom_ff};
      rem_in  = fits ? diff[32:0] : shifted[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_LAST_STEP;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff   <= 33'(div_req.thr[30:1]);
         lsb_ff   <= div_req.thr[0];
         denom_ff <= div_req.denom;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- sv/lbc_engine.sv -----
// Frame sequencer: shared multiplier, filter and envelope state, delay line control.
module lbc_engine #(
   parameter int DEPTH = 64,
   parameter int PTR_W = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lbc_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lbc_pkg::SAMPLE_W-1:0] req_left,
   input  logic signed [lbc_pkg::SAMPLE_W-1:0] req_right,
   input  logic                                req_last,
   output logic                                res_valid,
   input  logic                                res_ready,
   output logic signed [lbc_pkg::SAMPLE_W-1:0] res_left,
   output logic signed [lbc_pkg::SAMPLE_W-1:0] res_right,
   output logic                                res_last,
   output logic                                mem_rd_en,
   output logic [PTR_W-1:0]                    mem_rd_addr,
   input  logic [2*lbc_pkg::SAMPLE_W-1:0]      mem_rd_data,
   output logic                                mem_wr_en,
   output logic [PTR_W-1:0]                    mem_wr_addr,
   output logic [2*lbc_pkg::SAMPLE_W-1:0]      mem_wr_data,
   output lbc_pkg::div_req_type                div_req,
   input  lbc_pkg::div_rsp_type                div_rsp
);
   import lbc_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'h00001,
      ST_LP_DL    = 19'h00002,
      ST_LP_DR    = 19'h00004,
      ST_LP_DW    = 19'h00008,
      ST_PEAK     = 19'h00010,
      ST_ENV_A    = 19'h00020,
      ST_ENV_B    = 19'h00040,
      ST_ENV_C    = 19'h00080,
      ST_OVER     = 19'h00100,
      ST_DIV_GO   = 19'h00200,
      ST_DIV_WAIT = 19'h00400,
      ST_LP_SL    = 19'h00800,
      ST_LP_SR    = 19'h01000,
      ST_F_BL     = 19'h02000,
      ST_F_BR     = 19'h04000,
      ST_F_GL     = 19'h08000,
      ST_F_GR     = 19'h10000,
      ST_OUT_R    = 19'h20000,
      ST_EMIT     = 19'h40000
   } state_type;

   function automatic logic signed [ACC_W-1:0] lp_next(
      input logic signed [ACC_W-1:0] lp,
      input logic signed [52:0]      p
   );
      logic signed [37:0] s;
      s = 38'(lp) + 38'($signed(p[52:16]));
      if (s > 38'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (s < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [52:0] p);
      logic signed [32:0] y;
      y = $signed(p[52:20]);
      if (y > 33'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (y < -33'sd8388608) begin
         return 24'sh800000;
      end
      return y[23:0];
   endfunction

   function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + 32'd1) : v;
   endfunction

   state_type state_ff, state_in;

   // filter and envelope state
   logic signed [ACC_W-1:0] dlpl_ff, dlpr_ff, slpl_ff, slpr_ff;
   logic [ACC_W-1:0]        env_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic                    wrapped_ff;

   // per-frame working registers
   logic signed [SAMPLE_W-1:0] xl_ff, xr_ff;
   logic                       last_ff;
   logic [ACC_W-1:0]           peak_ff;
   logic [15:0]                coef_ff;
   logic [47:0]                acc_ff;
   logic [QUOT_W-1:0]          gain_ff;
   logic signed [34:0]         mixl_ff, mixr_ff;
   logic signed [SAMPLE_W-1:0] resl_ff, resr_ff;
   logic signed [52:0]         prod_ff;

   logic signed [34:0]         mul_a;
   logic signed [17:0]         mul_b;
   logic                       accept;
   logic                       reduce;
   logic [ACC_W-1:0]           thr;
   logic [ACC_W-1:0]           peak_in;
   logic [48:0]                env_sum;
   logic signed [SAMPLE_W-1:0] dl, dr;
   logic signed [34:0]         dl_hi, dr_hi;
   logic signed [37:0]         mix_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign thr       = {1'b0, cfg.threshold, 8'd0};
   assign reduce    = (cfg.threshold >= MIN_THRESHOLD) && (env_ff > thr);
   assign peak_in   = (mag(dlpr_ff) > mag(dlpl_ff)) ? mag(dlpr_ff) : mag(dlpl_ff);
   assign env_sum   = 49'(acc_ff) + 49'(prod_ff[47:0]);

   // entries not yet written since reset read as zero
   assign dl    = wrapped_ff ? $signed(mem_rd_data[SAMPLE_W-1:0]) : '0;
   assign dr    = wrapped_ff ? $signed(mem_rd_data[2*SAMPLE_W-1:SAMPLE_W]) : '0;
   assign dl_hi = 35'($signed({dl, 8'd0})) - 35'(slpl_ff);
   assign dr_hi = 35'($signed({dr, 8'd0})) - 35'(slpr_ff);
   assign mix_in = 38'($signed(prod_ff[52:16]))
                 + 38'((state_ff == ST_F_BR) ? dl_hi : dr_hi);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LP_DL: begin
            mul_a = 35'($signed({xl_ff, 8'd0})) - 35'(dlpl_ff);
            mul_b = LP_WEIGHT;
         end
         ST_LP_DR: begin
            mul_a = 35'($signed({xr_ff, 8'd0})) - 35'(dlpr_ff);
            mul_b = LP_WEIGHT;
         end
         ST_ENV_A: begin
            mul_a = 35'(env_ff);
            mul_b = 18'(coef_ff);
         end
         ST_ENV_B: begin
            mul_a = 35'(peak_ff);
            mul_b = 18'(17'd65536 - 17'(coef_ff));
         end
         ST_OVER: begin
            mul_a = 35'(env_ff - thr);
            mul_b = OVER_WEIGHT;
         end
         ST_LP_SL: begin
            mul_a = dl_hi;
            mul_b = LP_WEIGHT;
         end
         ST_LP_SR: begin
            mul_a = dr_hi;
            mul_b = LP_WEIGHT;
         end
         ST_F_BL: begin
            mul_a = 35'(slpl_ff);
            mul_b = 18'(gain_ff);
         end
         ST_F_BR: begin
            mul_a = 35'(slpr_ff);
            mul_b = 18'(gain_ff);
         end
         ST_F_GL: begin
            mul_a = mixl_ff;
            mul_b = 18'(cfg.makeup_gain);
         end
         ST_F_GR: begin
            mul_a = mixr_ff;
            mul_b = 18'(cfg.makeup_gain);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = cfg.enable ? ST_LP_DL : ST_EMIT;
         ST_LP_DL:    state_in = ST_LP_DR;
         ST_LP_DR:    state_in = ST_LP_DW;
         ST_LP_DW:    state_in = ST_PEAK;
         ST_PEAK:     state_in = ST_ENV_A;
         ST_ENV_A:    state_in = ST_ENV_B;
         ST_ENV_B:    state_in = ST_ENV_C;
         ST_ENV_C:    state_in = ST_OVER;
         ST_OVER:     state_in = reduce ? ST_DIV_GO : ST_LP_SL;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_rsp.done) state_in = ST_LP_SL;
         ST_LP_SL:    state_in = ST_LP_SR;
         ST_LP_SR:    state_in = ST_F_BL;
         ST_F_BL:     state_in = ST_F_BR;
         ST_F_BR:     state_in = ST_F_GL;
         ST_F_GL:     state_in = ST_F_GR;
         ST_F_GR:     state_in = ST_OUT_R;
         ST_OUT_R:    state_in = ST_EMIT;
         ST_EMIT:     if (res_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dlpl_ff    <= '0;
         dlpr_ff    <= '0;
         slpl_ff    <= '0;
         slpr_ff    <= '0;
         env_ff     <= '0;
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LP_DR) dlpl_ff <= lp_next(dlpl_ff, prod_ff);
         if (state_ff == ST_LP_DW) dlpr_ff <= lp_next(dlpr_ff, prod_ff);
         if (state_ff == ST_ENV_C) env_ff  <= env_sum[47:16];
         if (state_ff == ST_LP_SR) slpl_ff <= lp_next(slpl_ff, prod_ff);
         if (state_ff == ST_F_BL)  slpr_ff <= lp_next(slpr_ff, prod_ff);
         if (state_ff == ST_OUT_R) begin
            if (ptr_ff == PTR_W'(DEPTH - 1)) begin
               ptr_ff     <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (accept) begin
         xl_ff   <= req_left;
         xr_ff   <= req_right;
         last_ff <= req_last;
         resl_ff <= req_left;
         resr_ff <= req_right;
      end
      if (state_ff == ST_PEAK) begin
         peak_ff <= peak_in;
         coef_ff <= (peak_in > env_ff) ? cfg.attack_coef : cfg.release_coef;
      end
      if (state_ff == ST_ENV_B) acc_ff <= prod_ff[47:0];
      if (state_ff == ST_OVER && !reduce) gain_ff <= UNITY_GAIN;
      if (state_ff == ST_DIV_WAIT && div_rsp.done) gain_ff <= div_rsp.quot;
      if (state_ff == ST_F_BR) mixl_ff <= mix_in[34:0];
      if (state_ff == ST_F_GL) mixr_ff <= mix_in[34:0];
      if (state_ff == ST_F_GR) resl_ff <= sat24(prod_ff);
      if (state_ff == ST_OUT_R) resr_ff <= sat24(prod_ff);
   end

   assign div_req.start = (state_ff == ST_DIV_GO);
   assign div_req.thr   = thr[30:0];
   assign div_req.denom = 33'(thr) + 33'(prod_ff[47:16]);

   assign mem_rd_en   = accept && cfg.enable;
   assign mem_rd_addr = ptr_ff;
   assign mem_wr_en   = (state_ff == ST_OUT_R);
   assign mem_wr_addr = ptr_ff;
   assign mem_wr_data = {xr_ff, xl_ff};

   assign res_valid = (state_ff == ST_EMIT);
   assign res_left  = resl_ff;
   assign res_right = resr_ff;
   assign res_last  = last_ff;

`ifndef SYNTH
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_F_BL |-> gain_ff <= UNITY_GAIN)
      else $error("gain above unity");

   a_env_bounded: assert property (@(posedge clock) disable iff (reset)
      env_ff <= 32'h80000000)
      else $error("envelope beyond full scale");

   a_mem_write_once: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> !mem_wr_en && state_ff == ST_EMIT)
      else $error("delay line written twice for one frame");
`endif

endmodule

// ----- sv/lookahead_bass_compressor_core.sv -----
// Lookahead low-band compressor: top level with result register.
//
// req_* carries one stereo frame per beat; rsp_* returns one compressed frame per beat,
// in order; csr_* writes the five control registers (index 0..4) and is always ready.
// Registers should be written only while no frame is in flight.
// The work of a frame runs as a sequence on one shared 35x18 multiplier; when the
// envelope rises above the threshold, gain reduction is active and the gain comes
// from a 17-step restoring divider, else the gain stays at unity.
// A new frame is taken only after the last frame's result has left the sequencer.
// With enable low a frame passes through unchanged and no state moves.
// req_tready is high only while the sequencer is idle, so frames are taken one at a time.
// The finished frame sits in an output register; if rsp_tready is low the next frame's
// result waits in the sequencer until that register frees.
// Reset clears filters, envelope, delay pointer and registers; the delay memory needs no
// clearing pass, since entries are tracked by pointer wrap and read as zero until written.
module lookahead_bass_compressor_core #(
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [47:0]                           req_tdata,  // left_in, right_in
   input  logic                                  req_tlast,  // block_end
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [47:0]                           rsp_tdata,  // left_out, right_out
   output logic                                  rsp_tlast,  // block_end_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import lbc_pkg::*;

   localparam int PTR_W = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                       res_valid, res_ready, res_last;
   logic signed [SAMPLE_W-1:0] res_left, res_right;
   logic                       mem_rd_en, mem_wr_en;
   logic [PTR_W-1:0]           mem_rd_addr, mem_wr_addr;
   logic [2*SAMPLE_W-1:0]      mem_rd_data, mem_wr_data;

   logic                       out_valid_ff;
   logic [2*SAMPLE_W-1:0]      out_data_ff;
   logic                       out_last_ff;

   lbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lbc_delay_mem #(
      .DEPTH  (LOOKAHEAD_DEPTH),
      .ADDR_W (PTR_W),
      .DATA_W (2*SAMPLE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lbc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lbc_engine #(
      .DEPTH (LOOKAHEAD_DEPTH),
      .PTR_W (PTR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_left    (req_tdata[23:0]),
      .req_right   (req_tdata[47:24]),
      .req_last    (req_tlast),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_left    (res_left),
      .res_right   (res_right),
      .res_last    (res_last),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   assign res_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_data_ff <= {res_right, res_left};
         out_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
